// ===== rtl/qfrt_pkg.sv =====
// Shared types and constants for the quoted-field record tokenizer.
package qfrt_pkg;

  localparam int MAX_FIELDS = 256;
  localparam int FIELD_CAP_INT = (MAX_FIELDS - 1 < 255) ? MAX_FIELDS - 1 : 255;
  localparam logic [7:0] FIELD_CAP = FIELD_CAP_INT[7:0];

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EOF    = 2'd1,
    ST_QUOTE  = 2'd2,
    ST_ESCAPE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    M_BEGIN      = 3'd0,
    M_PLAIN      = 3'd1,
    M_PLAIN_ESC  = 3'd2,
    M_QUOTED     = 3'd3,
    M_QUOTED_ESC = 3'd4,
    M_BETWEEN    = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] content_byte;
    logic       has_content;
    logic       field_start;
    logic       field_end;
    logic       record_end;
    logic [7:0] field_index;
    status_t    status;
  } result_t;

endpackage

// ===== rtl/qfrt_parser.sv =====
// Parser state machine: mode and field counter, one item per step.
module qfrt_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_value,
  input  logic              end_of_input,
  output logic              emit,
  output qfrt_pkg::result_t res
);
  import qfrt_pkg::*;

  mode_t      mode, mode_next;
  logic [7:0] field_counter, field_counter_next;

  always_comb begin
    mode_next          = mode;
    field_counter_next = field_counter;
    emit               = 1'b0;
    res                = '0;
    res.status         = ST_OK;
    res.field_index    = field_counter;

    case (mode)
      M_PLAIN: begin
        if (end_of_input) begin
          emit = 1'b1;
          res.field_end = 1'b1;
          res.status = ST_EOF;
          mode_next = M_BEGIN;
          field_counter_next = '0;
        end else if (byte_value == CH_BACKSLASH) begin
          mode_next = M_PLAIN_ESC;
        end else if (byte_value == CH_SPACE) begin
          emit = 1'b1;
          res.field_end = 1'b1;
          mode_next = M_BETWEEN;
        end else if (byte_value == CH_NEWLINE) begin
          emit = 1'b1;
          res.field_end = 1'b1;
          res.record_end = 1'b1;
          mode_next = M_BEGIN;
          field_counter_next = '0;
        end else begin
          emit = 1'b1;
          res.content_byte = byte_value;
          res.has_content = 1'b1;
        end
      end
      M_PLAIN_ESC, M_QUOTED_ESC: begin
        emit = 1'b1;
        if (end_of_input) begin
          res.status = ST_ESCAPE;
          mode_next = M_BEGIN;
          field_counter_next = '0;
        end else begin
          res.content_byte = byte_value;
          res.has_content = 1'b1;
          mode_next = (mode == M_PLAIN_ESC) ? M_PLAIN : M_QUOTED;
        end
      end
      M_QUOTED: begin
        if (end_of_input) begin
          emit = 1'b1;
          res.status = ST_QUOTE;
          mode_next = M_BEGIN;
          field_counter_next = '0;
        end else if (byte_value == CH_BACKSLASH) begin
          mode_next = M_QUOTED_ESC;
        end else if (byte_value == CH_QUOTE) begin
          emit = 1'b1;
          res.field_end = 1'b1;
          mode_next = M_BETWEEN;
        end else begin
          emit = 1'b1;
          res.content_byte = byte_value;
          res.has_content = 1'b1;
        end
      end
      M_BETWEEN: begin
        if (end_of_input) begin
          emit = 1'b1;
          res.status = ST_EOF;
          mode_next = M_BEGIN;
          field_counter_next = '0;
        end else if (byte_value == CH_NEWLINE) begin
          emit = 1'b1;
          res.record_end = 1'b1;
          mode_next = M_BEGIN;
          field_counter_next = '0;
        end else if (byte_value != CH_SPACE) begin
          // next field of the record; index saturates at the cap
          if (field_counter < FIELD_CAP) begin
            field_counter_next = field_counter + 8'd1;
          end
          emit = 1'b1;
          res.field_start = 1'b1;
          res.field_index = field_counter_next;
          if (byte_value == CH_QUOTE) begin
            mode_next = M_QUOTED;
          end else if (byte_value == CH_BACKSLASH) begin
            mode_next = M_PLAIN_ESC;
          end else begin
            mode_next = M_PLAIN;
            res.content_byte = byte_value;
            res.has_content = 1'b1;
          end
        end
      end
      default: begin
        // record begin: skip leading spaces and blank lines
        mode_next = M_BEGIN;
        field_counter_next = '0;
        res.field_index = '0;
        if (end_of_input) begin
          emit = 1'b1;
          res.status = ST_EOF;
        end else if (!(byte_value inside {CH_SPACE, CH_NEWLINE})) begin
          emit = 1'b1;
          res.field_start = 1'b1;
          if (byte_value == CH_QUOTE) begin
            mode_next = M_QUOTED;
          end else if (byte_value == CH_BACKSLASH) begin
            mode_next = M_PLAIN_ESC;
          end else begin
            mode_next = M_PLAIN;
            res.content_byte = byte_value;
            res.has_content = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_BEGIN;
      field_counter <= '0;
    end else if (step) begin
      mode <= mode_next;
      field_counter <= field_counter_next;
    end
  end

endmodule

// ===== rtl/quoted_field_record_tokenizer.sv =====
// Top level of the quoted-field record tokenizer: input register, parser, result register.
//
// Input stream: one item per byte of text, or an end-of-input mark on tuser.
// Output stream: zero or one item per input item, carrying the content byte,
// field start/end marks, field index and a status; tlast marks record end.
// Spaces split fields, newline ends a record, double quotes enclose a field
// and a backslash makes the next byte literal.
// An item is held in the input register and its result is then presented on
// the output register. Throughput: one item per cycle while the receiver does
// not stall the output.
// A stalled receiver holds the result register; the input register keeps
// taking items that make no result and otherwise waits with its item, so
// tready falls only when both registers are occupied and stuck.
// Reset (synchronous, active high) empties both registers and puts the
// parser at record begin with field index zero.
module quoted_field_record_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tuser,   // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] content_byte, [8] field_start, [9] field_end,
  // [17:10] field_index, [19:18] status, [23:20] zero
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] has_content
  output logic        m_axis_tlast    // record_end
);
  import qfrt_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eoi;
  logic       out_valid;
  result_t    out_res;

  logic       emit;
  result_t    res;
  logic       out_room;
  logic       step;

  assign out_room      = !out_valid || m_axis_tready;
  assign step          = in_valid && (!emit || out_room);
  assign s_axis_tready = !in_valid || step;

  qfrt_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .byte_value   (in_byte),
    .end_of_input (in_eoi),
    .emit         (emit),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_eoi  <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_room) begin
      out_valid <= step && emit;
    end
    if (out_room && step && emit) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_res.status, out_res.field_index,
                          out_res.field_end, out_res.field_start, out_res.content_byte};
  assign m_axis_tuser  = out_res.has_content;
  assign m_axis_tlast  = out_res.record_end;

endmodule
